@@ rtl/rss_pkg.sv @@
// shared constants, codes and types for the range symbol substitution block
package rss_pkg;

   localparam int BUFFER_DEPTH  = 1024;
   localparam int ALPHABET_SIZE = 26;

   localparam int SYM_W  = 5;
   localparam int POS_W  = 10;
   localparam int LEN_W  = 11;
   localparam int LANE_W = 4;
   localparam int LANES  = 1 << LANE_W;
   localparam int ROW_W  = POS_W - LANE_W;
   localparam int ROWS   = BUFFER_DEPTH / LANES;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_REPLACE = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_READ
   } state_type;

   typedef logic [LANES-1:0][SYM_W-1:0] row_type;

   typedef struct packed {
      logic [LANE_W-1:0] lane_lo;
      logic [LANE_W-1:0] lane_hi;
      logic [SYM_W-1:0]  match_symbol;
      logic [SYM_W-1:0]  new_symbol;
   } sweep_ctrl_type;

endpackage

@@ rtl/rss_row_update.sv @@
// substitution of matching symbols across the selected lanes of one buffer row
module rss_row_update
   import rss_pkg::*;
(
   input  row_type        row_data,
   input  sweep_ctrl_type ctrl,
   output row_type        row_new
);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if ((LANE_W'(l) >= ctrl.lane_lo) && (LANE_W'(l) <= ctrl.lane_hi) &&
             (row_data[l] == ctrl.match_symbol)) begin
            row_new[l] = ctrl.new_symbol;
         end else begin
            row_new[l] = row_data[l];
         end
      end
   end

endmodule

@@ rtl/range_symbol_substitution.sv @@
// top level: symbol buffer with load, ranged replace and read requests
//
//  channel   ports                                  handshake
//  request   start, busy, req_opcode .. req_new_symbol   taken when start and not busy
//  response  rsp_strobe, rsp_read_position, rsp_read_symbol  one cycle, no back-pressure
//  config    csr_write_enable, csr_write_data       written on any enabled edge
//
//  buffer is 64 rows of 16 symbols in one memory, one read and one write per cycle
//  load: the row lane is written at the accepting edge, busy stays low
//  read: busy in ST_READ after acceptance, strobe in the cycle after ST_READ
//  replace: busy while ST_SWEEP walks from the first row to the clamped last row, one row rewritten per cycle
//  empty or invalid replace and unused opcode: no busy cycle at all
//  memory contents are not cleared by reset; only control state is
module range_symbol_substitution
   import rss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_opcode,
   input  logic [POS_W-1:0] req_first_position,
   input  logic [POS_W-1:0] req_last_position,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic [SYM_W-1:0] req_new_symbol,
   output logic             rsp_strobe,
   output logic [POS_W-1:0] rsp_read_position,
   output logic [SYM_W-1:0] rsp_read_symbol,
   input  logic             csr_write_enable,
   input  logic [LEN_W-1:0] csr_write_data
);

   row_type mem [ROWS];

   state_type state_ff, state_in;
   logic [LEN_W-1:0] text_length_ff;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  first_row_ff, end_row_ff;
   logic [LANE_W-1:0] first_lane_ff, last_lane_ff;
   logic [SYM_W-1:0]  sym_ff, nsym_ff;
   logic [LANE_W-1:0] rd_lane_ff;
   logic [POS_W-1:0]  rd_pos_ff;
   logic              rd_ok_ff;
   row_type           rd_data_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [SYM_W-1:0]  rsp_sym_ff, rsp_sym_in;

   logic [LEN_W-1:0]  len_eff;
   logic [POS_W-1:0]  last_clamp;
   logic              accept, first_ok, load_ok, repl_go;
   logic              is_load, is_repl, is_read;
   logic              rd_en, wr_en;
   logic [ROW_W-1:0]  rd_row, wr_row;
   logic [LANES-1:0]  wr_mask;
   row_type           wr_data, row_new;
   sweep_ctrl_type    sweep_ctrl;

   // request decode
   assign is_load = (req_opcode == OP_LOAD);
   assign is_repl = (req_opcode == OP_REPLACE);
   assign is_read = (req_opcode == OP_READ);
   assign accept  = start && !busy;

   assign len_eff  = (text_length_ff > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH)
                                                             : text_length_ff;
   assign first_ok = ({1'b0, req_first_position} < len_eff);
   assign load_ok  = first_ok && ({1'b0, req_symbol} < (SYM_W+1)'(ALPHABET_SIZE));

   always_comb begin
      if ({1'b0, req_last_position} >= len_eff) begin
         last_clamp = POS_W'(len_eff - LEN_W'(1));
      end else begin
         last_clamp = req_last_position;
      end
   end

   assign repl_go = (len_eff != '0) &&
                    ({1'b0, req_new_symbol} < (SYM_W+1)'(ALPHABET_SIZE)) &&
                    ({1'b0, req_symbol} < (SYM_W+1)'(ALPHABET_SIZE)) &&
                    (req_first_position <= last_clamp);

   // row update for the sweep
   assign sweep_ctrl.lane_lo      = (row_ff == first_row_ff) ? first_lane_ff : '0;
   assign sweep_ctrl.lane_hi      = (row_ff == end_row_ff) ? last_lane_ff : '1;
   assign sweep_ctrl.match_symbol = sym_ff;
   assign sweep_ctrl.new_symbol   = nsym_ff;

   rss_row_update u_row_update (
      .row_data (rd_data_ff),
      .ctrl     (sweep_ctrl),
      .row_new  (row_new)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_read) begin
               state_in = ST_READ;
            end else if (accept && is_repl && repl_go) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (row_ff == end_row_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the controller
   always_comb begin
      busy          = 1'b0;
      rd_en         = 1'b0;
      rd_row        = req_first_position[POS_W-1:LANE_W];
      wr_en         = 1'b0;
      wr_row        = req_first_position[POS_W-1:LANE_W];
      wr_mask       = '0;
      wr_data       = {LANES{req_symbol}};
      row_in        = row_ff;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            row_in = req_first_position[POS_W-1:LANE_W];
            if (accept && (is_read || (is_repl && repl_go))) begin
               rd_en = 1'b1;
            end
            if (accept && is_load && load_ok) begin
               wr_en = 1'b1;
               wr_mask[req_first_position[LANE_W-1:0]] = 1'b1;
            end
         end
         ST_SWEEP: begin
            busy    = 1'b1;
            wr_en   = 1'b1;
            wr_row  = row_ff;
            wr_mask = '1;
            wr_data = row_new;
            rd_row  = row_ff + ROW_W'(1);
            row_in  = row_ff + ROW_W'(1);
            if (row_ff != end_row_ff) begin
               rd_en = 1'b1;
            end
         end
         ST_READ: begin
            busy          = 1'b1;
            rsp_strobe_in = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign rsp_sym_in = rd_ok_ff ? rd_data_ff[rd_lane_ff] : '0;

   // symbol memory
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
      for (int l = 0; l < LANES; l++) begin
         if (wr_en && wr_mask[l]) begin
            mem[wr_row][l] <= wr_data[l];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         text_length_ff <= LEN_W'(BUFFER_DEPTH);
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            text_length_ff <= csr_write_data;
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      if (accept) begin
         first_row_ff  <= req_first_position[POS_W-1:LANE_W];
         first_lane_ff <= req_first_position[LANE_W-1:0];
         end_row_ff    <= last_clamp[POS_W-1:LANE_W];
         last_lane_ff  <= last_clamp[LANE_W-1:0];
         sym_ff        <= req_symbol;
         nsym_ff       <= req_new_symbol;
         rd_lane_ff    <= req_first_position[LANE_W-1:0];
         rd_pos_ff     <= req_first_position;
         rd_ok_ff      <= first_ok;
      end
      if (rsp_strobe_in) begin
         rsp_pos_ff <= rd_pos_ff;
         rsp_sym_ff <= rsp_sym_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_position = rsp_pos_ff;
   assign rsp_read_symbol   = rsp_sym_ff;

   a_strobe_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_READ))
      else $error("response strobe without a read cycle");

   a_read_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && is_read) |=> (state_ff == ST_READ))
      else $error("read request not followed by read cycle");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (row_ff <= end_row_ff))
      else $error("sweep row past the end of the range");

   a_sweep_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && (row_ff != end_row_ff)) |=>
         ((state_ff == ST_SWEEP) && (row_ff == $past(row_ff) + ROW_W'(1))))
      else $error("sweep did not advance by one row");

endmodule

@@ bench/range_symbol_substitution_tb.sv @@
// testbench for the range symbol substitution block: directed table then random requests
`timescale 1ns / 100ps
module range_symbol_substitution_tb
   import rss_pkg::*;
();

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 80;
   localparam int REPORT_LINES  = 200;
   localparam int PHASES        = 7;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int PHASE_LENGTH [PHASES] = '{1024, 17, 1, 300, 0, 2047, 64};
   localparam int PHASE_ITEMS  [PHASES] = '{500, 150, 80, 400, 40, 500, 200};
   localparam int PHASE_IDLE   [PHASES] = '{8, 8, 82, 82, 82, 0, 0};

   typedef struct packed {
      logic [1:0]       opcode;
      logic [POS_W-1:0] first_pos;
      logic [POS_W-1:0] last_pos;
      logic [SYM_W-1:0] sym;
      logic [SYM_W-1:0] new_sym;
      logic             has_expected;
      logic [SYM_W-1:0] expected_symbol;
   } request_row_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [SYM_W-1:0] symbol;
   } read_result_type;

   // run with text length 1000, so 1023 lies past the end
   localparam int DIRECTED_COUNT = 24;
   localparam request_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_LOAD,    10'd0,    10'd0,    5'd0,  5'd0,  1'b0, 5'd0},
      '{OP_LOAD,    10'd999,  10'd0,    5'd25, 5'd0,  1'b0, 5'd0},
      '{OP_LOAD,    10'd1023, 10'd0,    5'd7,  5'd0,  1'b0, 5'd0},
      '{OP_READ,    10'd1023, 10'd1023, 5'd31, 5'd31, 1'b1, 5'd0},
      '{OP_READ,    10'd0,    10'd0,    5'd0,  5'd0,  1'b1, 5'd0},
      '{OP_READ,    10'd999,  10'd0,    5'd0,  5'd0,  1'b1, 5'd25},
      '{OP_LOAD,    10'd0,    10'd0,    5'd31, 5'd0,  1'b0, 5'd0},
      '{OP_READ,    10'd0,    10'd0,    5'd0,  5'd0,  1'b1, 5'd0},
      '{OP_LOAD,    10'd5,    10'd0,    5'd3,  5'd0,  1'b0, 5'd0},
      '{OP_LOAD,    10'd6,    10'd0,    5'd3,  5'd0,  1'b0, 5'd0},
      '{OP_LOAD,    10'd7,    10'd0,    5'd4,  5'd0,  1'b0, 5'd0},
      '{OP_REPLACE, 10'd0,    10'd1023, 5'd3,  5'd9,  1'b0, 5'd0},
      '{OP_READ,    10'd5,    10'd0,    5'd0,  5'd0,  1'b0, 5'd0},
      '{OP_READ,    10'd6,    10'd0,    5'd0,  5'd0,  1'b0, 5'd0},
      '{OP_REPLACE, 10'd0,    10'd1023, 5'd9,  5'd26, 1'b0, 5'd0},
      '{OP_READ,    10'd5,    10'd0,    5'd0,  5'd0,  1'b0, 5'd0},
      '{OP_REPLACE, 10'd0,    10'd999,  5'd31, 5'd1,  1'b0, 5'd0},
      '{OP_READ,    10'd7,    10'd0,    5'd0,  5'd0,  1'b0, 5'd0},
      '{OP_REPLACE, 10'd7,    10'd6,    5'd4,  5'd0,  1'b0, 5'd0},
      '{OP_READ,    10'd7,    10'd0,    5'd0,  5'd0,  1'b1, 5'd4},
      '{OP_REPLACE, 10'd999,  10'd1023, 5'd25, 5'd24, 1'b0, 5'd0},
      '{OP_READ,    10'd999,  10'd0,    5'd0,  5'd0,  1'b0, 5'd0},
      '{OP_UNUSED,  10'd5,    10'd1023, 5'd31, 5'd31, 1'b0, 5'd0},
      '{OP_READ,    10'd5,    10'd0,    5'd0,  5'd0,  1'b0, 5'd0}
   };

   logic             clock              = 1'b0;
   logic             reset              = 1'b1;
   logic             start              = 1'b0;
   logic             busy;
   logic [1:0]       req_opcode         = '0;
   logic [POS_W-1:0] req_first_position = '0;
   logic [POS_W-1:0] req_last_position  = '0;
   logic [SYM_W-1:0] req_symbol         = '0;
   logic [SYM_W-1:0] req_new_symbol     = '0;
   logic             rsp_strobe;
   logic [POS_W-1:0] rsp_read_position;
   logic [SYM_W-1:0] rsp_read_symbol;
   logic             csr_write_enable   = 1'b0;
   logic [LEN_W-1:0] csr_write_data     = '0;

   logic [SYM_W-1:0] symbol_image [BUFFER_DEPTH] = '{default: '0};
   bit               text_written [BUFFER_DEPTH] = '{default: 1'b0};
   int unsigned      written_positions [$];
   logic [LEN_W-1:0] text_len = LEN_W'(BUFFER_DEPTH);
   read_result_type  pending_reads [$];
   int               failures        = 0;
   int               cycle_count     = 0;
   int               sender_idle_pct = 0;

   range_symbol_substitution DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_first_position (req_first_position),
      .req_last_position  (req_last_position),
      .req_symbol         (req_symbol),
      .req_new_symbol     (req_new_symbol),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_position  (rsp_read_position),
      .rsp_read_symbol    (rsp_read_symbol),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned active_length();
      return (text_len > BUFFER_DEPTH) ? BUFFER_DEPTH : text_len;
   endfunction

   // updates the symbol image and returns 1 when the request produces a read response
   function automatic bit apply_request(input request_row_type row,
                                        output read_result_type result);
      int unsigned len_eff;
      int unsigned stop;
      int unsigned i;
      bit          produced;
      len_eff  = active_length();
      produced = 1'b0;
      result   = '0;
      case (row.opcode)
         OP_LOAD: begin
            if (row.first_pos < len_eff && row.sym < ALPHABET_SIZE) begin
               symbol_image[row.first_pos] = row.sym;
               if (!text_written[row.first_pos]) begin
                  text_written[row.first_pos] = 1'b1;
                  written_positions.push_back(row.first_pos);
               end
            end
         end
         OP_REPLACE: begin
            if (len_eff != 0 && row.new_sym < ALPHABET_SIZE) begin
               stop = (row.last_pos > len_eff - 1) ? len_eff - 1 : row.last_pos;
               for (i = row.first_pos; i <= stop; i++) begin
                  if (symbol_image[i] == row.sym) symbol_image[i] = row.new_sym;
               end
            end
         end
         OP_READ: begin
            result.position = row.first_pos;
            result.symbol   = (row.first_pos < len_eff) ? symbol_image[row.first_pos] : '0;
            produced        = 1'b1;
         end
         default: ;
      endcase
      return produced;
   endfunction

   function automatic logic [SYM_W-1:0] random_symbol();
      if ($urandom_range(0, 1) != 0) return SYM_W'($urandom_range(0, 3));
      return SYM_W'($urandom_range(0, ALPHABET_SIZE - 1));
   endfunction

   function automatic int unsigned any_written_position();
      return written_positions[$urandom_range(0, written_positions.size() - 1)];
   endfunction

   function automatic request_row_type random_request();
      request_row_type row;
      int unsigned     len_eff;
      int unsigned     pick;
      int unsigned     tail;
      len_eff       = active_length();
      row           = '0;
      row.first_pos = POS_W'($urandom_range(0, BUFFER_DEPTH - 1));
      row.last_pos  = POS_W'($urandom_range(0, BUFFER_DEPTH - 1));
      row.sym       = random_symbol();
      row.new_sym   = random_symbol();
      pick          = $urandom_range(0, 99);
      if (pick < 5) begin
         case ($urandom_range(0, 2))
            0: row.opcode = OP_UNUSED;
            1: begin
               row.opcode = OP_LOAD;
               row.sym    = SYM_W'($urandom_range(ALPHABET_SIZE, (1 << SYM_W) - 1));
            end
            default: begin
               row.opcode  = OP_REPLACE;
               row.new_sym = SYM_W'($urandom_range(ALPHABET_SIZE, (1 << SYM_W) - 1));
            end
         endcase
      end else if (pick < 40) begin
         row.opcode = OP_LOAD;
         if (len_eff != 0 && $urandom_range(0, 9) != 0) begin
            row.first_pos = POS_W'($urandom_range(0, len_eff - 1));
         end
      end else if (pick < 65) begin
         row.opcode = OP_REPLACE;
         if (len_eff != 0 && $urandom_range(0, 9) != 0) begin
            row.first_pos = POS_W'($urandom_range(0, len_eff - 1));
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            tail         = row.first_pos + $urandom_range(0, 40);
            row.last_pos = POS_W'((tail > BUFFER_DEPTH - 1) ? BUFFER_DEPTH - 1 : tail);
         end else if (pick >= 90) begin
            row.first_pos = '0;
            row.last_pos  = POS_W'(BUFFER_DEPTH - 1);
         end
         if (written_positions.size() != 0 && $urandom_range(0, 9) < 6) begin
            row.sym = symbol_image[any_written_position()];
         end
      end else begin
         row.opcode = OP_READ;
         if (written_positions.size() != 0 && $urandom_range(0, 9) < 8) begin
            row.first_pos = POS_W'(any_written_position());
         end
         // never read a position inside the text that has not been loaded
         if (row.first_pos < len_eff && !text_written[row.first_pos]) begin
            if (written_positions.size() != 0) row.first_pos = POS_W'(any_written_position());
            else row.opcode = OP_LOAD;
         end
      end
      return row;
   endfunction

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= REPORT_LINES) $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic issue_request(input request_row_type row);
      read_result_type result;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_opcode         <= row.opcode;
      req_first_position <= row.first_pos;
      req_last_position  <= row.last_pos;
      req_symbol         <= row.sym;
      req_new_symbol     <= row.new_sym;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (apply_request(row, result)) begin
         if (row.has_expected) result.symbol = row.expected_symbol;
         pending_reads.push_back(result);
      end
   endtask

   task automatic drain_reads(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_text_length(input logic [LEN_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      text_len          = value;
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin : response_check
      read_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reads.size() == 0) begin
            report_mismatch($sformatf("unexpected response position %0d symbol %0d",
                                      rsp_read_position, rsp_read_symbol));
         end else begin
            want = pending_reads.pop_front();
            if (rsp_read_position !== want.position)
               report_mismatch($sformatf("read_position %0d, expected %0d",
                                         rsp_read_position, want.position));
            if (rsp_read_symbol !== want.symbol)
               report_mismatch($sformatf("read_symbol %0d at position %0d, expected %0d",
                                         rsp_read_symbol, want.position, want.symbol));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      int p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_text_length(LEN_W'(1000));
      sender_idle_pct = 8;
      for (r = 0; r < DIRECTED_COUNT; r++) issue_request(DIRECTED_ROWS[r]);
      for (p = 0; p < PHASES; p++) begin
         drain_reads(SETTLE_CYCLES);
         write_text_length(LEN_W'(PHASE_LENGTH[p]));
         sender_idle_pct = PHASE_IDLE[p];
         repeat (PHASE_ITEMS[p]) begin
            if ($urandom_range(0, 199) == 0) drain_reads(0);
            issue_request(random_request());
         end
      end
      drain_reads(SETTLE_CYCLES);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rss_pkg.sv
rtl/rss_row_update.sv
rtl/range_symbol_substitution.sv
bench/range_symbol_substitution_tb.sv
